### src/lesf_pkg.sv
package lesf_pkg;

  // Map bounds
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 65536;

  // Derived widths
  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int SIDE_W = COL_W;

  // Result field widths
  localparam int TOP_ROW_W = 16;
  localparam int LEFT_COL_W = 10;
  localparam int SIDE_OUT_W = 11;

  localparam logic [7:0] NEWLINE_BYTE    = 8'd10;
  localparam logic [7:0] EMPTY_CHAR_RST  = 8'd46;

  // Side-buffer access for one cycle
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SIDE_W-1:0] wr_data;
  } mem_req_t;

endpackage

### src/lesf_side_mem.sv
module lesf_side_mem (
  input  logic                         clk,
  input  lesf_pkg::mem_req_t           req,
  output logic [lesf_pkg::SIDE_W-1:0]  rd_data
);
  import lesf_pkg::*;

  logic [SIDE_W-1:0] mem [MAX_COLS];
  logic [SIDE_W-1:0] rd_data_r;
  logic [SIDE_W-1:0] fwd_data_r;
  logic              fwd_hit_r;

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port; catch a write to the same entry at the same edge
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_addr];
      fwd_hit_r  <= req.wr_en && (req.wr_addr == req.rd_addr);
      fwd_data_r <= req.wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : rd_data_r;

endmodule

### src/largest_empty_square_finder_unit.sv
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | in_tdata: cell_char; in_tlast: map_end
// out_    | out | out_tvalid/out_tready | out_tdata: found, top_row, left_col,
//         |     |                     |   side_length, overflow
// cfg_    | in  | cfg_valid/cfg_ready | cfg_data: empty_char
//
// One map byte per cycle while in_tready is high. A byte is classified at
// acceptance (the side-buffer read is issued then) and resolved in the resolve
// stage against the registered read data, where the min-plus-one update and
// the write-back happen. out_tvalid rises once the final byte has left the
// resolve stage and its result is held in the result register.
// rst_n is synchronous and active low; the side buffer is not cleared.
// Input stalls only while a finished result waits and the final byte of the
// next map is ready to produce another one.
module largest_empty_square_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // [7:0] cell_char
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] found, [16:1] top_row, [26:17] left_col, [37:27] side_length,
  // [38] overflow, [39] zero
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] empty_char
  input  logic [7:0]  cfg_data,
  input  logic        cfg_valid,
  output logic        cfg_ready
);
  import lesf_pkg::*;

  typedef enum logic [1:0] {
    K_CELL,
    K_NEWLINE,
    K_SKIP
  } kind_t;

  logic [7:0] empty_char_r;

  // Front counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  kind_t            kind_in;
  logic             in_acc;

  // Resolve stage
  logic              s1_v_r;
  kind_t             s1_kind_r;
  logic              s1_free_r;
  logic              s1_last_r;
  logic              s1_first_r;
  logic [ADDR_W-1:0] s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic              s1_adv;

  // Run state
  logic [SIDE_W-1:0]     diag_r, diag_nxt;
  logic [SIDE_W-1:0]     left_r, left_nxt;
  logic [SIDE_W-1:0]     best_side_r, best_side_nxt;
  logic [TOP_ROW_W-1:0]  best_row_r, best_row_nxt;
  logic [LEFT_COL_W-1:0] best_col_r, best_col_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [SIDE_W-1:0] up_raw;
  logic [SIDE_W-1:0] up;
  logic [SIDE_W-1:0] min_ul;
  logic [SIDE_W-1:0] min_all;
  logic [SIDE_W-1:0] side;
  logic [ROW_W-1:0]  row_calc;
  logic [COL_W-1:0]  col_calc;

  logic       out_v_r;
  logic [39:0] out_data_r;

  mem_req_t mreq;

  assign cfg_ready = 1'b1;

  // Hold the free-cell byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_char_r <= EMPTY_CHAR_RST;
    end else if (cfg_valid) begin
      empty_char_r <= cfg_data;
    end
  end

  // Stall the resolve stage only when its result has nowhere to go
  assign s1_adv    = s1_v_r && !(s1_last_r && out_v_r && !out_tready);
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Classify the incoming byte and advance counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (row_r >= ROW_W'(MAX_ROWS)) begin
      kind_in = K_SKIP;
    end else if (in_tdata == NEWLINE_BYTE) begin
      kind_in = K_NEWLINE;
      row_nxt = row_r + ROW_W'(1);
      col_nxt = '0;
    end else if (col_r >= COL_W'(MAX_COLS)) begin
      kind_in = K_SKIP;
    end else begin
      kind_in = K_CELL;
      col_nxt = col_r + COL_W'(1);
    end
    if (in_tlast) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // Capture the transaction into the resolve stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= kind_in;
      s1_free_r  <= (in_tdata == empty_char_r);
      s1_last_r  <= in_tlast;
      s1_first_r <= (row_r == '0);
      s1_col_r   <= col_r[ADDR_W-1:0];
      s1_row_r   <= row_r;
    end
  end

  // Side buffer: read at acceptance, write back on resolve
  always_comb begin
    mreq.rd_en   = in_acc && (kind_in == K_CELL);
    mreq.rd_addr = col_r[ADDR_W-1:0];
    mreq.wr_en   = s1_adv && (s1_kind_r == K_CELL);
    mreq.wr_addr = s1_col_r;
    mreq.wr_data = side;
  end

  lesf_side_mem u_side_mem (
    .clk     (clk),
    .req     (mreq),
    .rd_data (up_raw)
  );

  // Min-plus-one update
  assign up       = s1_first_r ? '0 : up_raw;
  assign min_ul   = (up < left_r) ? up : left_r;
  assign min_all  = (min_ul < diag_r) ? min_ul : diag_r;
  assign side     = s1_free_r ? (min_all + SIDE_W'(1)) : '0;
  assign row_calc = s1_row_r + ROW_W'(1) - ROW_W'(side);
  assign col_calc = COL_W'(s1_col_r) + COL_W'(1) - side;

  always_comb begin
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    best_side_nxt = best_side_r;
    best_row_nxt  = best_row_r;
    best_col_nxt  = best_col_r;
    ovf_nxt       = ovf_r;
    unique case (s1_kind_r)
      K_CELL: begin
        diag_nxt = up;
        left_nxt = side;
        if (side > best_side_r) begin
          best_side_nxt = side;
          best_row_nxt  = row_calc[TOP_ROW_W-1:0];
          best_col_nxt  = col_calc[LEFT_COL_W-1:0];
        end
      end
      K_NEWLINE: begin
        diag_nxt = '0;
        left_nxt = '0;
      end
      K_SKIP: begin
        ovf_nxt = 1'b1;
      end
      default: begin
        ovf_nxt = ovf_r;
      end
    endcase
  end

  // Update run state; drop it after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_r      <= '0;
      left_r      <= '0;
      best_side_r <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      ovf_r       <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        diag_r      <= '0;
        left_r      <= '0;
        best_side_r <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
        ovf_r       <= 1'b0;
      end else begin
        diag_r      <= diag_nxt;
        left_r      <= left_nxt;
        best_side_r <= best_side_nxt;
        best_row_r  <= best_row_nxt;
        best_col_r  <= best_col_nxt;
        ovf_r       <= ovf_nxt;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_data_r <= {1'b0, ovf_nxt, SIDE_OUT_W'(best_side_nxt), best_col_nxt,
                     best_row_nxt, (best_side_nxt != '0)};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

### src/lesf_checker.sv
module lesf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tlast,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // found agrees with a nonzero side
  a_found_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[37:27] != 11'd0)))
    else $error("found flag disagrees with side length");

  // Side never exceeds the column bound, pad bit stays low
  a_side_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37:27] <= 11'd1024) && !out_tdata[39])
    else $error("side length out of range");

  // A fresh result follows an accepted final byte
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a final byte");

endmodule

bind largest_empty_square_finder_unit lesf_checker u_lesf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tlast   (in_tlast),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
